// ----- sv/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// Register indexes, result kinds and the item record handed to the result
// buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned PAT_WORDS = 4;
  localparam int unsigned PAT_BYTES = 32;
  localparam int unsigned PADDR_W   = 6;
  localparam int unsigned REG_IDX_W = 3;

  // Register indexes (byte address is 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_PAT_WORD_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_WORD_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT_WORD_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT_WORD_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LENGTH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REPORT_ALL = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BASE       = 3'd6;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [BYTE_W-1:0] WILDCARD = 8'h00;

  // One accepted byte that causes at least one result
  typedef struct packed {
    logic               report;    // emit a match result
    logic               new_first; // this match is the region's first
    logic               summary;   // emit the end-of-region summary
    logic               found;     // region has a match after this byte
    logic [ADDR_W-1:0]  offset;    // start offset of the match
    logic [COUNT_W-1:0] total;     // match count after this byte
  } wbps_item_t;

endpackage

`default_nettype wire

// ----- sv/wbps_cell.sv -----
// ----------------------------------------------------------------------------
// wbps_cell: one window cell
// Holds one byte of the window, hands it to the next cell on every beat and
// compares the byte arriving at it with its aligned pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell
  import wbps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              shift_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic [BYTE_W-1:0] pat_i,
  input  wire logic              active_i,
  output logic      [BYTE_W-1:0] byte_o,
  output logic                   match_o
);

  logic [BYTE_W-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  // Cells past the pattern length always agree; a zero pattern byte matches anything
  assign match_o = !active_i || (pat_i == WILDCARD) || (pat_i == byte_i);

endmodule

`default_nettype wire

// ----- sv/wbps_result_buf.sv -----
// ----------------------------------------------------------------------------
// wbps_result_buf: result staging and output register
// Holds one item's pending match and summary results, forms the addresses
// and feeds them one beat at a time into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_result_buf
  import wbps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire wbps_item_t         item_i,
  output logic                    ready_o,
  input  wire logic [ADDR_W-1:0]  region_base_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    result_kind_o,
  output logic      [ADDR_W-1:0]  match_address_o,
  output logic      [COUNT_W-1:0] match_total_o,
  output logic                    final_result_o
);

  logic               m_pend_q, m_pend_d;
  logic               s_pend_q, s_pend_d;
  wbps_item_t         item_q;
  logic [ADDR_W-1:0]  first_addr_q;
  logic               o_vld_q, o_vld_d;
  logic               o_kind_q;
  logic [ADDR_W-1:0]  o_addr_q;
  logic [COUNT_W-1:0] o_total_q;
  logic               o_final_q;

  logic               o_load;
  logic               move;
  logic [ADDR_W-1:0]  match_addr;
  logic               nxt_kind;
  logic [ADDR_W-1:0]  nxt_addr;
  logic               nxt_final;

  assign o_load     = !o_vld_q || out_ready_i;
  assign move       = o_load && (m_pend_q || s_pend_q);
  assign match_addr = region_base_i + item_q.offset;
  assign ready_o    = (!m_pend_q && !s_pend_q) || (move && (m_pend_q ^ s_pend_q));

  // Match result goes out ahead of the summary
  always_comb begin
    if (m_pend_q) begin
      nxt_kind  = KIND_MATCH;
      nxt_addr  = match_addr;
      nxt_final = !item_q.summary;
    end else begin
      nxt_kind  = KIND_SUMMARY;
      nxt_addr  = item_q.found ? first_addr_q : '0;
      nxt_final = 1'b1;
    end
  end

  always_comb begin
    m_pend_d = m_pend_q && !(move && m_pend_q);
    s_pend_d = s_pend_q && !(move && !m_pend_q);
    if (push_i) begin
      m_pend_d = item_i.report;
      s_pend_d = item_i.summary;
    end
  end

  always_comb begin
    o_vld_d = o_vld_q;
    if (move) begin
      o_vld_d = 1'b1;
    end else if (out_ready_i) begin
      o_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_pend_q <= 1'b0;
      s_pend_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      m_pend_q <= m_pend_d;
      s_pend_q <= s_pend_d;
      o_vld_q  <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
    if (move && m_pend_q && item_q.new_first) begin
      first_addr_q <= match_addr;
    end
    if (move) begin
      o_kind_q  <= nxt_kind;
      o_addr_q  <= nxt_addr;
      o_total_q <= item_q.total;
      o_final_q <= nxt_final;
    end
  end

  assign out_valid_o     = o_vld_q;
  assign result_kind_o   = o_kind_q;
  assign match_address_o = o_addr_q;
  assign match_total_o   = o_total_q;
  assign final_result_o  = o_final_q;

endmodule

`default_nettype wire

// ----- sv/wildcard_byte_pattern_scanner_core.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core: wildcard byte signature scanner
// Scans a byte stream for a pattern of up to 32 bytes, zero bytes wild.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one region byte per beat,
//   with end_of_region_i set on the region's last byte. A row of window cells
//   shifts the byte in and compares the whole window in the same cycle, so
//   one byte is taken every cycle while results drain.
//   Output channel (out_valid_o / out_ready_i) carries match results and,
//   on the last byte, an end-of-region summary; a byte gives 0, 1 or 2 beats.
//   A result passes through the staging register, then the output register.
//   A byte that yields two results holds the input back, as the output
//   register moves one result per cycle while the receiver takes them.
//   When the receiver stalls, the staging register and output register fill
//   and in_ready_o drops; bytes without results keep flowing while staging
//   holds at most one pending result that can move on.
//   Reset clears position, match count and first-match state; pattern length
//   resets to 1, others to 0. The user must write the APB port (64-bit data,
//   register i at byte address 8*i) only while the scanner idles; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scanner_core
  import wbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  parameter int unsigned POSITION_BITS     = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [ADDR_W-1:0]  pwdata,
  output logic      [ADDR_W-1:0]  prdata,
  output logic                    pready,
  // Byte input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [BYTE_W-1:0]  data_byte_i,
  input  wire logic               end_of_region_i,
  // Result output
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    result_kind_o,
  output logic      [ADDR_W-1:0]  match_address_o,
  output logic      [COUNT_W-1:0] match_total_o,
  output logic                    final_result_o
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

  // Configuration registers
  logic [PAT_WORDS-1:0][ADDR_W-1:0] pat_q;
  logic [LEN_W-1:0]                 len_q;
  logic                             report_all_q;
  logic [ADDR_W-1:0]                base_q;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q        <= '0;
      len_q        <= LEN_W'(1);
      report_all_q <= 1'b0;
      base_q       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAT_WORD_0: pat_q[0]     <= pwdata;
        REG_PAT_WORD_1: pat_q[1]     <= pwdata;
        REG_PAT_WORD_2: pat_q[2]     <= pwdata;
        REG_PAT_WORD_3: pat_q[3]     <= pwdata;
        REG_PAT_LENGTH: len_q        <= pwdata[LEN_W-1:0];
        REG_REPORT_ALL: report_all_q <= pwdata[0];
        REG_BASE:       base_q       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PAT_WORD_0: prdata = pat_q[0];
      REG_PAT_WORD_1: prdata = pat_q[1];
      REG_PAT_WORD_2: prdata = pat_q[2];
      REG_PAT_WORD_3: prdata = pat_q[3];
      REG_PAT_LENGTH: prdata = ADDR_W'(len_q);
      REG_REPORT_ALL: prdata = ADDR_W'(report_all_q);
      REG_BASE:       prdata = base_q;
      default:        prdata = '0;
    endcase
  end

  // Active length: zero acts as one, clamp to the cell count
  logic [LEN_W-1:0] len_act;

  always_comb begin
    priority if (len_q == '0) begin
      len_act = LEN_W'(1);
    end else if (len_q > MAX_LEN) begin
      len_act = MAX_LEN;
    end else begin
      len_act = len_q;
    end
  end

  logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes;
  assign pat_bytes = pat_q;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // Window cell row: cell 0 takes the newest byte
  logic [MAX_PATTERN_BYTES:0][BYTE_W-1:0] chain;
  logic [MAX_PATTERN_BYTES-1:0]           cell_match;

  assign chain[0] = data_byte_i;

  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
    logic [LEN_W-1:0] pidx;
    logic             active;

    assign active = LEN_W'(j) < len_act;
    // Cell j lines up with pattern byte len-1-j
    assign pidx   = len_act - LEN_W'(1) - LEN_W'(j);

    wbps_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (accept),
      .byte_i   (chain[j]),
      .pat_i    (pat_bytes[pidx[LEN_W-2:0]]),
      .active_i (active),
      .byte_o   (chain[j+1]),
      .match_o  (cell_match[j])
    );
  end

  // Region state
  logic [POSITION_BITS-1:0] pos_q;
  logic                     found_q;
  logic [COUNT_W-1:0]       cnt_q;

  logic [POSITION_BITS-1:0] len_less1;
  logic                     hit;
  logic [COUNT_W-1:0]       cnt_new;
  logic                     found_new;
  logic                     buf_ready;
  wbps_item_t               item;

  assign len_less1 = POSITION_BITS'(len_act - LEN_W'(1));
  assign hit       = (pos_q >= len_less1) && (&cell_match);
  assign found_new = found_q || hit;

  always_comb begin
    cnt_new = cnt_q;
    if (hit && (cnt_q != '1)) begin
      cnt_new = cnt_q + COUNT_W'(1);
    end
  end

  always_comb begin
    item.report    = hit && (report_all_q || !found_q);
    item.new_first = hit && !found_q;
    item.summary   = end_of_region_i;
    item.found     = found_new;
    item.offset    = ADDR_W'(pos_q - len_less1);
    item.total     = cnt_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else if (accept) begin
      if (end_of_region_i) begin
        pos_q   <= '0;
        found_q <= 1'b0;
        cnt_q   <= '0;
      end else begin
        pos_q   <= pos_q + POSITION_BITS'(1);
        found_q <= found_new;
        cnt_q   <= cnt_new;
      end
    end
  end

  assign in_ready_o = buf_ready;

  wbps_result_buf u_result_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (accept && (item.report || item.summary)),
    .item_i          (item),
    .ready_o         (buf_ready),
    .region_base_i   (base_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .match_address_o (match_address_o),
    .match_total_o   (match_total_o),
    .final_result_o  (final_result_o)
  );

endmodule

`default_nettype wire

// ----- test/scan_checker.sv -----
// ----------------------------------------------------------------------------
// scan_checker: result predictor and comparator for the byte pattern scanner
// Follows the APB register writes and every byte beat, predicts the match
// and summary results, and compares each result beat with the oldest one
// still expected.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scan_checker
  import wbps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic               pready_i,
  input  wire logic [PADDR_W-1:0] paddr_i,
  input  wire logic [ADDR_W-1:0]  pwdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [BYTE_W-1:0]  data_byte_i,
  input  wire logic               end_of_region_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic               result_kind_i,
  input  wire logic [ADDR_W-1:0]  match_address_i,
  input  wire logic [COUNT_W-1:0] match_total_i,
  input  wire logic               final_result_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] total;
    logic               last;
  } scan_result_t;

  localparam logic [COUNT_W-1:0] TOTAL_MAX = '1;

  // Register copy
  logic [ADDR_W-1:0]  sig_word [PAT_WORDS];
  logic [LEN_W-1:0]   sig_len;
  logic               report_every;
  logic [ADDR_W-1:0]  base_addr;

  // Region state; window[0] is the newest byte
  logic [BYTE_W-1:0]  window [PAT_BYTES];
  logic [31:0]        position;
  logic               found;
  logic [ADDR_W-1:0]  first_addr;
  logic [COUNT_W-1:0] hits;

  scan_result_t       expected_results [$];
  int                 mismatches;

  task automatic clear_region();
    for (int k = 0; k < PAT_BYTES; k++) window[k] = '0;
    position   = '0;
    found      = 1'b0;
    first_addr = '0;
    hits       = '0;
  endtask

  task automatic scan_byte(input logic [BYTE_W-1:0] data, input logic last);
    int unsigned       span;
    logic              hit;
    logic [BYTE_W-1:0] sig;
    logic [31:0]       offset;
    logic [ADDR_W-1:0] addr;
    scan_result_t      res;
    span = (sig_len == 0) ? 1 : (sig_len > PAT_BYTES) ? PAT_BYTES : sig_len;
    for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = data;
    hit = (position >= span - 1);
    for (int k = 0; k < span; k++) begin
      sig = sig_word[k / 8][8 * (k % 8) +: 8];
      if (sig != WILDCARD && sig != window[span - 1 - k]) hit = 1'b0;
    end
    if (hit) begin
      offset = position - (span - 1);
      addr   = base_addr + {{(ADDR_W - 32){1'b0}}, offset};
      if (hits != TOTAL_MAX) hits = hits + 1;
      if (report_every || !found) begin
        res = '{kind: KIND_MATCH, address: addr, total: hits, last: !last};
        expected_results.insert(expected_results.size(), res);
      end
      if (!found) begin
        found      = 1'b1;
        first_addr = addr;
      end
    end
    position = position + 1;
    if (last) begin
      res = '{kind: KIND_SUMMARY, address: found ? first_addr : '0, total: hits,
              last: 1'b1};
      expected_results.insert(expected_results.size(), res);
      clear_region();
    end
  endtask

  task automatic check_result(input scan_result_t actual);
    scan_result_t want;
    if (expected_results.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result kind %0b addr %h total %0d final %0b",
                 $realtime, actual.kind, actual.address, actual.total, actual.last);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (want.kind !== actual.kind || want.address !== actual.address ||
          want.total !== actual.total || want.last !== actual.last) begin
        if (mismatches < 10)
          $display({"%0t: result mismatch, expected kind %0b addr %h total %0d final %0b,",
                    " got kind %0b addr %h total %0d final %0b"},
                   $realtime, want.kind, want.address, want.total, want.last,
                   actual.kind, actual.address, actual.total, actual.last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < PAT_WORDS; w++) sig_word[w] = '0;
      sig_len      = 1;
      report_every = 1'b0;
      base_addr    = '0;
      clear_region();
      expected_results.delete();
      mismatches       = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:3])
          REG_PAT_WORD_0: sig_word[0]  = pwdata_i;
          REG_PAT_WORD_1: sig_word[1]  = pwdata_i;
          REG_PAT_WORD_2: sig_word[2]  = pwdata_i;
          REG_PAT_WORD_3: sig_word[3]  = pwdata_i;
          REG_PAT_LENGTH: sig_len      = pwdata_i[LEN_W-1:0];
          REG_REPORT_ALL: report_every = pwdata_i[0];
          REG_BASE:       base_addr    = pwdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) scan_byte(data_byte_i, end_of_region_i);
      if (out_valid_i && out_ready_i)
        check_result('{kind: result_kind_i, address: match_address_i,
                       total: match_total_i, last: final_result_i});
      mismatch_count_o <= mismatches;
      pending_o        <= expected_results.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the wildcard byte pattern scanner
// Programs the pattern registers over APB, streams directed and random
// regions with idle gaps on the byte side and stalls on the result side,
// and lets scan_checker predict and compare every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import wbps_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned IDLE_PCT    = 38;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum {SIG_MIXED, SIG_WILD, SIG_ONES} sig_style_e;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [ADDR_W-1:0]  pwdata      = '0;
  logic [ADDR_W-1:0]  prdata;
  logic               pready;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  data_byte   = '0;
  logic               region_end  = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               result_kind;
  logic [ADDR_W-1:0]  match_address;
  logic [COUNT_W-1:0] match_total;
  logic               final_result;

  int                 mismatch_count;
  int                 pending;
  int unsigned        quiet_cycles = 0;
  bit                 calm = 1'b0;
  logic [BYTE_W-1:0]  sig_bytes [PAT_BYTES];

  always #5 clk = ~clk;

  wildcard_byte_pattern_scanner_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .end_of_region_i (region_end),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_kind_o   (result_kind),
    .match_address_o (match_address),
    .match_total_o   (match_total),
    .final_result_o  (final_result)
  );

  scan_checker result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .data_byte_i      (data_byte),
    .end_of_region_i  (region_end),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .result_kind_i    (result_kind),
    .match_address_i  (match_address),
    .match_total_i    (match_total),
    .final_result_i   (final_result),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Stall the result side at random unless in a calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] sig_word(input int w);
    logic [ADDR_W-1:0] word;
    for (int j = 0; j < 8; j++) word[8*j +: 8] = sig_bytes[8*w + j];
    return word;
  endfunction

  task automatic load_pattern();
    apb_write(REG_PAT_WORD_0, sig_word(0));
    apb_write(REG_PAT_WORD_1, sig_word(1));
    apb_write(REG_PAT_WORD_2, sig_word(2));
    apb_write(REG_PAT_WORD_3, sig_word(3));
  endtask

  // Present one beat, with a random gap ahead of it, and hold until taken
  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid   <= 1'b1;
    data_byte  <= value;
    region_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid before calling; wait out all results and the pipeline
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int items, input logic [LEN_W-1:0] len_val,
                           input logic every, input logic [ADDR_W-1:0] base_val,
                           input sig_style_e style);
    int                span;
    int                rlen;
    int                sent;
    logic [BYTE_W-1:0] region_q [$];
    for (int k = 0; k < PAT_BYTES; k++) begin
      case (style)
        SIG_WILD: sig_bytes[k] = WILDCARD;
        SIG_ONES: sig_bytes[k] = 8'hFF;
        default:  sig_bytes[k] = ($urandom_range(0, 99) < 30) ? WILDCARD
                                                               : 8'($urandom_range(1, 255));
      endcase
    end
    load_pattern();
    apb_write(REG_PAT_LENGTH, ADDR_W'(len_val));
    apb_write(REG_REPORT_ALL, ADDR_W'(every));
    apb_write(REG_BASE, base_val);
    span = (len_val == 0) ? 1 : (len_val > PAT_BYTES) ? PAT_BYTES : len_val;
    sent = 0;
    while (sent < items) begin
      region_q.delete();
      if ($urandom_range(0, 9) == 0) rlen = $urandom_range(1, span);
      else if (span > 8)             rlen = $urandom_range(span, span + 40);
      else                           rlen = $urandom_range(1, 20);
      // Plant whole pattern copies, with wildcard slots filled at random, among single pattern and random bytes
      while (region_q.size() < rlen) begin
        if (rlen - region_q.size() >= span && $urandom_range(0, 99) < 35) begin
          for (int k = 0; k < span; k++)
            region_q.insert(region_q.size(),
                            (sig_bytes[k] == WILDCARD) ? 8'($urandom) : sig_bytes[k]);
        end else if ($urandom_range(0, 99) < 40) begin
          region_q.insert(region_q.size(), sig_bytes[$urandom_range(0, span - 1)]);
        end else begin
          region_q.insert(region_q.size(), 8'($urandom));
        end
      end
      // A region cut at the phase end carries over into the next setting
      for (int i = 0; i < rlen && sent < items; i++) begin
        send_byte(region_q[i], i == rlen - 1);
        sent++;
      end
    end
    in_valid <= 1'b0;
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: one wildcard byte, so every byte matches
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h5A, 1'b1);
    in_valid <= 1'b0;
    settle();

    // FF ?? 80, all matches, base at the top of the address space
    for (int k = 0; k < PAT_BYTES; k++) sig_bytes[k] = WILDCARD;
    sig_bytes[0] = 8'hFF;
    sig_bytes[2] = 8'h80;
    load_pattern();
    apb_write(REG_PAT_LENGTH, ADDR_W'(3));
    apb_write(REG_REPORT_ALL, ADDR_W'(1));
    apb_write(REG_BASE, '1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    in_valid <= 1'b0;
    settle();

    // First match only; later ones still count
    apb_write(REG_REPORT_ALL, ADDR_W'(0));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h80, 1'b1);
    in_valid <= 1'b0;
    settle();

    apb_write(REG_UNUSED, {$urandom, $urandom});
    run_phase(250, LEN_W'(4), 1'b1, {$urandom, $urandom}, SIG_MIXED);
    run_phase(150, LEN_W'(32), 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, SIG_MIXED);
    run_phase(150, LEN_W'(0), 1'b0, '0, SIG_ONES);
    run_phase(100, LEN_W'(63), 1'b1, '1, SIG_WILD);
    run_phase(100, LEN_W'(33), 1'b0, {$urandom, $urandom}, SIG_MIXED);
    calm = 1'b1;
    run_phase(250, LEN_W'($urandom_range(2, 8)), 1'b1, {$urandom, $urandom}, SIG_MIXED);
    calm = 1'b0;
    run_phase(250, LEN_W'($urandom_range(1, 3)), 1'($urandom), {$urandom, $urandom},
              SIG_MIXED);

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/wbps_pkg.sv
sv/wbps_cell.sv
sv/wbps_result_buf.sv
sv/wildcard_byte_pattern_scanner_core.sv
test/scan_checker.sv
test/testbench.sv
